// ===== hw/rtl/bhj_pkg.sv =====
// ----------------------------------------------------------------------------
// bhj_pkg
// Shared types and constants of the bucket hash join engine.
// ----------------------------------------------------------------------------
package bhj_pkg;

    // default number of table slots
    localparam int TABLE_DEPTH_DEF = 1024;

    localparam int KEY_W    = 32;
    localparam int RID_W    = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int FILL_W   = 11;

    // one table entry: {valid, key, rid}
    localparam int ENTRY_W = 1 + KEY_W + RID_W;

    // stream payload widths
    localparam int S_TDATA_W = KEY_W + RID_W;
    localparam int M_TDATA_W = RID_W + RID_W;

    // configuration register file
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 1;
    localparam int RADIX_W   = 5;
    localparam int TBITS_W   = 4;

    localparam logic [RADIX_W-1:0] RADIX_BITS_RST = 5'd0;
    localparam logic [TBITS_W-1:0] TABLE_BITS_RST = 4'd10;
    localparam logic [FILL_W-1:0]  FILL_MAX       = 11'd2047;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_RADIX_BITS = 1'b0,
        REG_TABLE_BITS = 1'b1
    } reg_idx_t;

    typedef enum logic [OP_W-1:0] {
        OP_BUILD = 2'd0,
        OP_PROBE = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED = 3'd0,
        STAT_FULL     = 3'd1,
        STAT_MATCH    = 3'd2,
        STAT_MISS     = 3'd3,
        STAT_CLEARED  = 3'd4
    } status_t;

    typedef struct packed {
        logic [RADIX_W-1:0] radix_bits;
        logic [TBITS_W-1:0] table_bits;
    } cfg_t;

endpackage

// ===== hw/rtl/bucket_hash_join_engine_unit.sv =====
// ----------------------------------------------------------------------------
// bucket_hash_join_engine_unit
// Hash join of one radix bucket over an open-addressed, linearly probed table.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake                   payload
//  -------   ---   -------------------------   ------------------------------
//  s_        in    s_tvalid / s_tready         tuser op, tdata key, row_id
//  m_        out   m_tvalid / m_tready         tuser status, tdata r_rid, s_rid
//  apb       in    psel & penable & pwrite     radix_bits @0x0, table_bits @0x4
//
//  Build/probe: an accept in S_IDLE, then S_SEARCH visits one slot per cycle
//  (the RAM read port fetches the next slot while the current one is
//  compared) until a hit (probe), an empty slot or the last slot ends it.
//  Clear: one RAM write per slot, swept in S_CLEAR for each clear item.
//  Reset: a clearing pass over every slot runs first; s_tready stays low.
//  m_ is a result register; a stalled m_tready holds the finishing item
//  and only then blocks s_tready.
//
module bucket_hash_join_engine_unit #(
    parameter int TABLE_DEPTH = bhj_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bhj_pkg::PADDR_W-1:0]     paddr,
    input  logic [bhj_pkg::PDATA_W-1:0]     pwdata,
    output logic [bhj_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bhj_pkg::S_TDATA_W-1:0]   s_tdata,   // key[31:0], row_id[63:32]
    input  logic [bhj_pkg::OP_W-1:0]        s_tuser,   // operation[1:0]
    // results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bhj_pkg::M_TDATA_W-1:0]   m_tdata,   // r_rid[31:0], s_rid[63:32]
    output logic [bhj_pkg::STATUS_W-1:0]    m_tuser    // status[2:0]
);

    localparam int AW = $clog2(TABLE_DEPTH);

    bhj_pkg::cfg_t                   cfg;
    logic                            mem_we;
    logic [AW-1:0]                   mem_waddr;
    logic [bhj_pkg::ENTRY_W-1:0]     mem_wdata;
    logic [AW-1:0]                   mem_raddr;
    logic [bhj_pkg::ENTRY_W-1:0]     mem_rdata;
    logic [bhj_pkg::RID_W-1:0]       r_rid;
    logic [bhj_pkg::RID_W-1:0]       s_rid;

    // register file; to be written only while the engine is idle, which the block does not enforce
    bhj_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // slot table: {valid, key, rid} per slot
    bhj_ram #(
        .WIDTH (bhj_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // sequencer: home slot hash, linear probe walk, clear sweep, result register
    bhj_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tuser),
        .in_key     (s_tdata[bhj_pkg::KEY_W-1:0]),
        .in_rid     (s_tdata[bhj_pkg::S_TDATA_W-1:bhj_pkg::KEY_W]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_r_rid  (r_rid),
        .out_s_rid  (s_rid),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    assign m_tdata = {s_rid, r_rid};

endmodule

// ===== hw/rtl/bhj_ram.sv =====
// ----------------------------------------------------------------------------
// bhj_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bhj_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/bhj_cfg.sv =====
// ----------------------------------------------------------------------------
// bhj_cfg
// APB register file: radix_bits and table_bits.
// ----------------------------------------------------------------------------
module bhj_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bhj_pkg::PADDR_W-1:0] paddr,
    input  logic [bhj_pkg::PDATA_W-1:0] pwdata,
    output logic [bhj_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output bhj_pkg::cfg_t               cfg
);

    logic [bhj_pkg::RADIX_W-1:0] radix_bits_reg;
    logic [bhj_pkg::TBITS_W-1:0] table_bits_reg;
    bhj_pkg::reg_idx_t           idx;
    logic                        wr_en;

    // word addressed, byte offset ignored
    assign idx    = bhj_pkg::reg_idx_t'(paddr[bhj_pkg::PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_bits_reg <= bhj_pkg::RADIX_BITS_RST;
            table_bits_reg <= bhj_pkg::TABLE_BITS_RST;
        end else if (wr_en) begin
            case (idx)
                bhj_pkg::REG_RADIX_BITS: begin
                    radix_bits_reg <= pwdata[bhj_pkg::RADIX_W-1:0];
                end
                bhj_pkg::REG_TABLE_BITS: begin
                    table_bits_reg <= pwdata[bhj_pkg::TBITS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            bhj_pkg::REG_RADIX_BITS: begin
                prdata = bhj_pkg::PDATA_W'(radix_bits_reg);
            end
            bhj_pkg::REG_TABLE_BITS: begin
                prdata = bhj_pkg::PDATA_W'(table_bits_reg);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign cfg.radix_bits = radix_bits_reg;
    assign cfg.table_bits = table_bits_reg;

endmodule

// ===== hw/rtl/bhj_ctrl.sv =====
// ----------------------------------------------------------------------------
// bhj_ctrl
// Probe sequencer: walks the slot table through the RAM, one slot per cycle,
// sweeps it clear at reset and on a clear item, and holds the result register.
// ----------------------------------------------------------------------------
module bhj_ctrl #(
    parameter int TABLE_DEPTH = bhj_pkg::TABLE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  bhj_pkg::cfg_t                     cfg,
    // input item
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bhj_pkg::OP_W-1:0]          in_op,
    input  logic [bhj_pkg::KEY_W-1:0]         in_key,
    input  logic [bhj_pkg::RID_W-1:0]         in_rid,
    // result item
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bhj_pkg::STATUS_W-1:0]      out_status,
    output logic [bhj_pkg::RID_W-1:0]         out_r_rid,
    output logic [bhj_pkg::RID_W-1:0]         out_s_rid,
    // slot RAM
    output logic                              mem_we,
    output logic [$clog2(TABLE_DEPTH)-1:0]    mem_waddr,
    output logic [bhj_pkg::ENTRY_W-1:0]       mem_wdata,
    output logic [$clog2(TABLE_DEPTH)-1:0]    mem_raddr,
    input  logic [bhj_pkg::ENTRY_W-1:0]       mem_rdata
);

    localparam int AW        = $clog2(TABLE_DEPTH);
    localparam int DEPTH_LOG = $clog2(TABLE_DEPTH + 1) - 1;  // log2 of largest pow2 in depth
    localparam int LGW       = $clog2(DEPTH_LOG + 1);
    localparam int CW        = DEPTH_LOG + 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SEARCH,
        S_CLEAR,
        S_REPLY
    } state_t;

    state_t                         state_reg, state_next;
    logic [bhj_pkg::OP_W-1:0]       op_reg, op_next;
    logic [bhj_pkg::KEY_W-1:0]      key_reg, key_next;
    logic [bhj_pkg::RID_W-1:0]      rid_reg, rid_next;
    logic [AW-1:0]                  pos_reg, pos_next;
    logic [CW-1:0]                  n_reg, n_next;
    logic [LGW-1:0]                 lg_reg, lg_next;
    logic [AW-1:0]                  sweep_reg, sweep_next;
    logic [bhj_pkg::FILL_W-1:0]     fill_reg, fill_next;
    logic                           out_valid_reg, out_valid_next;
    logic [bhj_pkg::STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [bhj_pkg::RID_W-1:0]      out_r_reg, out_r_next;
    logic [bhj_pkg::RID_W-1:0]      out_s_reg, out_s_next;

    logic [LGW-1:0]                 lg_cfg;
    logic [AW-1:0]                  mask_cfg, mask_reg;
    logic [bhj_pkg::KEY_W-1:0]      key_shifted;
    logic [AW-1:0]                  home_pos;
    logic [AW-1:0]                  pos_inc;
    logic [CW-1:0]                  size_reg;
    logic                           last_slot;
    logic                           out_free;
    logic                           rd_valid;
    logic [bhj_pkg::KEY_W-1:0]      rd_key;
    logic [bhj_pkg::RID_W-1:0]      rd_rid;
    logic                           done;
    logic                           do_insert;
    bhj_pkg::status_t               done_status;
    logic [bhj_pkg::RID_W-1:0]      done_r;
    logic [bhj_pkg::RID_W-1:0]      done_s;

    // slots in use: 2^table_bits, capped at the largest power of two in the RAM
    assign lg_cfg = ({1'b0, cfg.table_bits} > 5'(DEPTH_LOG)) ? LGW'(DEPTH_LOG)
                                                             : LGW'(cfg.table_bits);
    assign mask_cfg    = ~({AW{1'b1}} << lg_cfg);
    assign mask_reg    = ~({AW{1'b1}} << lg_reg);
    assign size_reg    = CW'(1) << lg_reg;
    assign key_shifted = in_key >> cfg.radix_bits;
    assign home_pos    = key_shifted[AW-1:0] & mask_cfg;
    assign pos_inc     = (pos_reg + AW'(1)) & mask_reg;
    assign last_slot   = (n_reg + CW'(1)) == size_reg;
    assign out_free    = !out_valid_reg || out_ready;

    assign rd_valid = mem_rdata[bhj_pkg::ENTRY_W-1];
    assign rd_key   = mem_rdata[bhj_pkg::KEY_W+bhj_pkg::RID_W-1:bhj_pkg::RID_W];
    assign rd_rid   = mem_rdata[bhj_pkg::RID_W-1:0];

    // decision on the slot whose data is back from the RAM
    always_comb begin
        done        = 1'b0;
        do_insert   = 1'b0;
        done_status = bhj_pkg::STAT_MISS;
        done_r      = '0;
        done_s      = '0;
        if (op_reg == bhj_pkg::OP_BUILD) begin
            if (!rd_valid) begin
                done        = 1'b1;
                do_insert   = 1'b1;
                done_status = bhj_pkg::STAT_INSERTED;
            end else if (last_slot) begin
                done        = 1'b1;
                done_status = bhj_pkg::STAT_FULL;
            end
        end else begin
            if (!rd_valid) begin
                done = 1'b1;
            end else if (rd_key == key_reg) begin
                done        = 1'b1;
                done_status = bhj_pkg::STAT_MATCH;
                done_r      = rd_rid;
                done_s      = rid_reg;
            end else if (last_slot) begin
                done = 1'b1;
            end
        end
    end

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        rid_next        = rid_reg;
        pos_next        = pos_reg;
        n_next          = n_reg;
        lg_next         = lg_reg;
        sweep_next      = sweep_reg;
        fill_next       = fill_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_r_next      = out_r_reg;
        out_s_next      = out_s_reg;
        in_ready        = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = pos_reg;
        mem_wdata       = '0;
        mem_raddr       = pos_reg;

        case (state_reg)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
                if (sweep_reg == LAST_SLOT) begin
                    state_next = S_IDLE;
                end else begin
                    sweep_next = sweep_reg + AW'(1);
                end
            end
            S_IDLE: begin
                in_ready  = 1'b1;
                mem_raddr = home_pos;
                if (in_valid) begin
                    op_next    = in_op;
                    key_next   = in_key;
                    rid_next   = in_rid;
                    pos_next   = home_pos;
                    n_next     = '0;
                    lg_next    = lg_cfg;
                    sweep_next = '0;
                    case (in_op)
                        bhj_pkg::OP_BUILD, bhj_pkg::OP_PROBE: begin
                            state_next = S_SEARCH;
                        end
                        bhj_pkg::OP_CLEAR: begin
                            state_next = S_CLEAR;
                        end
                        default: begin
                            state_next = S_REPLY;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (!done) begin
                    // fetch the next slot while this one is checked
                    mem_raddr = pos_inc;
                    pos_next  = pos_inc;
                    n_next    = n_reg + CW'(1);
                end else if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = done_status;
                    out_r_next      = done_r;
                    out_s_next      = done_s;
                    state_next      = S_IDLE;
                    if (do_insert) begin
                        mem_we    = 1'b1;
                        mem_wdata = {1'b1, key_reg, rid_reg};
                        if (fill_reg != bhj_pkg::FILL_MAX) begin
                            fill_next = fill_reg + bhj_pkg::FILL_W'(1);
                        end
                    end
                end
                // stalled on a full result register: re-read to hold the data
            end
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
                if (sweep_reg != LAST_SLOT) begin
                    sweep_next = sweep_reg + AW'(1);
                end else if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = bhj_pkg::STAT_CLEARED;
                    out_r_next      = '0;
                    out_s_next      = '0;
                    fill_next       = '0;
                    state_next      = S_IDLE;
                end
            end
            S_REPLY: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = bhj_pkg::STAT_MISS;
                    out_r_next      = '0;
                    out_s_next      = '0;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            sweep_reg     <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
        op_reg         <= op_next;
        key_reg        <= key_next;
        rid_reg        <= rid_next;
        pos_reg        <= pos_next;
        n_reg          <= n_next;
        lg_reg         <= lg_next;
        out_status_reg <= out_status_next;
        out_r_reg      <= out_r_next;
        out_s_reg      <= out_s_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_r_rid  = out_r_reg;
    assign out_s_rid  = out_s_reg;

endmodule

// ===== tb/bucket_hash_join_engine_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bucket_hash_join_engine_unit_tb
// Self-checking bench for the bucket hash join engine.
// The bench keeps its own copy of the linear-probing table and predicts one
// result per input transfer. A short table of directed rows comes first.
// Random join buckets follow: configure, usually clear, build, probe. Result
// transfers are checked in order against the predicted queue, and both
// stream sides are throttled.
// ----------------------------------------------------------------------------
module bucket_hash_join_engine_unit_tb;
    import bhj_pkg::*;

    localparam int DEPTH       = TABLE_DEPTH_DEF;
    localparam int PHASE_ITEMS = 434;
    localparam int MAX_REPORTS = 10;
    // worst case: every item walks the whole table under heavy stalls
    localparam int TIMEOUT_NS  = 200_000_000;

    typedef struct packed {
        status_t            status;
        logic [RID_W-1:0]   r_rid;
        logic [RID_W-1:0]   s_rid;
    } join_result_t;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_SET_RADIX,
        ROW_SET_TBITS
    } row_kind_t;

    // directed row; config rows carry the register value in key
    typedef struct packed {
        row_kind_t          kind;
        op_t                op;
        logic [KEY_W-1:0]   key;
        logic [RID_W-1:0]   rid;
        logic               typed;
        join_result_t       res;
    } stim_row_t;

    localparam join_result_t NO_RES = '{STAT_INSERTED, 32'h0, 32'h0};

    localparam int N_ROWS = 33;
    localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
        // empty table after reset, 1024 slots, no shift
        '{ROW_ITEM, OP_PROBE, 32'h0, 32'h1, 1'b1, '{STAT_MISS, 32'h0, 32'h0}},
        '{ROW_ITEM, OP_BUILD, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, NO_RES},
        '{ROW_ITEM, OP_PROBE, 32'hFFFFFFFF, 32'h0, 1'b1,
          '{STAT_MATCH, 32'hFFFFFFFF, 32'h0}},
        '{ROW_ITEM, OP_BUILD, 32'h0, 32'h0, 1'b1, NO_RES},
        // same home slot as key 0, lands one slot further
        '{ROW_ITEM, OP_BUILD, 32'h400, 32'h12345678, 1'b1, NO_RES},
        '{ROW_ITEM, OP_PROBE, 32'h400, 32'hA5A5A5A5, 1'b1,
          '{STAT_MATCH, 32'h12345678, 32'hA5A5A5A5}},
        // duplicate key: probe returns the first one stored
        '{ROW_ITEM, OP_BUILD, 32'h0, 32'hDEADBEEF, 1'b1, NO_RES},
        '{ROW_ITEM, OP_PROBE, 32'h0, 32'hCAFEF00D, 1'b1,
          '{STAT_MATCH, 32'h0, 32'hCAFEF00D}},
        '{ROW_ITEM, OP_NOP, 32'h5, 32'h7, 1'b1, '{STAT_MISS, 32'h0, 32'h0}},
        '{ROW_ITEM, OP_CLEAR, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1,
          '{STAT_CLEARED, 32'h0, 32'h0}},
        '{ROW_ITEM, OP_PROBE, 32'h0, 32'h1, 1'b1, '{STAT_MISS, 32'h0, 32'h0}},
        // one slot, widest shift
        '{ROW_SET_TBITS, OP_NOP, 32'h0, 32'h0, 1'b0, NO_RES},
        '{ROW_SET_RADIX, OP_NOP, 32'd31, 32'h0, 1'b0, NO_RES},
        '{ROW_ITEM, OP_BUILD, 32'h80000000, 32'h1, 1'b1, NO_RES},
        '{ROW_ITEM, OP_BUILD, 32'h1, 32'h2, 1'b1, '{STAT_FULL, 32'h0, 32'h0}},
        // no empty slot: walk covers the table once and misses
        '{ROW_ITEM, OP_PROBE, 32'h1, 32'h3, 1'b1, '{STAT_MISS, 32'h0, 32'h0}},
        '{ROW_ITEM, OP_PROBE, 32'h80000000, 32'h3, 1'b1,
          '{STAT_MATCH, 32'h1, 32'h3}},
        '{ROW_ITEM, OP_CLEAR, 32'h0, 32'h0, 1'b1, '{STAT_CLEARED, 32'h0, 32'h0}},
        // eight slots, wrap-around, then shrink and grow back
        '{ROW_SET_TBITS, OP_NOP, 32'd3, 32'h0, 1'b0, NO_RES},
        '{ROW_SET_RADIX, OP_NOP, 32'd0, 32'h0, 1'b0, NO_RES},
        '{ROW_ITEM, OP_BUILD, 32'h7, 32'h9, 1'b0, NO_RES},
        '{ROW_ITEM, OP_BUILD, 32'hF, 32'hA, 1'b0, NO_RES},
        '{ROW_SET_TBITS, OP_NOP, 32'd2, 32'h0, 1'b0, NO_RES},
        '{ROW_ITEM, OP_PROBE, 32'h7, 32'h11, 1'b0, NO_RES},
        '{ROW_ITEM, OP_PROBE, 32'hF, 32'h12, 1'b0, NO_RES},
        '{ROW_SET_TBITS, OP_NOP, 32'd3, 32'h0, 1'b0, NO_RES},
        '{ROW_ITEM, OP_PROBE, 32'hF, 32'h13, 1'b0, NO_RES},
        // table_bits above the depth is clipped to the full table
        '{ROW_SET_TBITS, OP_NOP, 32'd15, 32'h0, 1'b0, NO_RES},
        '{ROW_SET_RADIX, OP_NOP, 32'd16, 32'h0, 1'b0, NO_RES},
        '{ROW_ITEM, OP_BUILD, 32'hABCD0123, 32'h55AA55AA, 1'b0, NO_RES},
        '{ROW_ITEM, OP_PROBE, 32'hABCD9999, 32'h1, 1'b0, NO_RES},
        '{ROW_ITEM, OP_PROBE, 32'hABCD0123, 32'hAA55AA55, 1'b0, NO_RES},
        '{ROW_ITEM, OP_CLEAR, 32'h0, 32'h0, 1'b0, NO_RES}
    };

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [PADDR_W-1:0]     paddr    = '0;
    logic [PDATA_W-1:0]     pwdata   = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;  // key[31:0], row_id[63:32]
    logic [OP_W-1:0]        s_tuser  = '0;  // operation[1:0]
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;        // r_rid[31:0], s_rid[63:32]
    logic [STATUS_W-1:0]    m_tuser;        // status[2:0]

    // throttle levels, percent of cycles spent idle
    int unsigned send_idle_pct = 16;
    int unsigned recv_idle_pct = 54;

    int unsigned items_sent = 0;
    int unsigned join_mismatches = 0;

    join_result_t join_results_due [$];

    // bench copy of the join table and its configuration
    bit                     slot_used   [DEPTH];
    bit [KEY_W-1:0]         slot_keys   [DEPTH];
    bit [RID_W-1:0]         slot_rids   [DEPTH];
    logic [RADIX_W-1:0]     cur_radix = RADIX_BITS_RST;
    logic [TBITS_W-1:0]     cur_tbits = TABLE_BITS_RST;

    bucket_hash_join_engine_unit #(
        .TABLE_DEPTH (DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // largest power of two not above both 2^tbits and the depth
    function automatic int unsigned slots_in_use(logic [TBITS_W-1:0] tbits);
        int unsigned size;
        size = 1 << tbits;
        while (size > DEPTH) size = size >> 1;
        return size;
    endfunction

    // apply one item to the bench table and return its join outcome
    function automatic join_result_t hash_join_step(op_t op, logic [KEY_W-1:0] key,
                                                    logic [RID_W-1:0] rid);
        join_result_t res;
        int unsigned  size;
        int unsigned  mask;
        int unsigned  pos;
        res  = '{STAT_MISS, 32'h0, 32'h0};
        size = slots_in_use(cur_tbits);
        mask = size - 1;
        pos  = (key >> cur_radix) & mask;
        case (op)
            OP_BUILD: begin
                res.status = STAT_FULL;
                for (int unsigned n = 0; n < size; n++) begin
                    if (!slot_used[pos]) begin
                        slot_used[pos] = 1'b1;
                        slot_keys[pos] = key;
                        slot_rids[pos] = rid;
                        res.status     = STAT_INSERTED;
                        break;
                    end
                    pos = (pos + 1) & mask;
                end
            end
            OP_PROBE: begin
                for (int unsigned n = 0; n < size; n++) begin
                    if (!slot_used[pos]) break;
                    if (slot_keys[pos] == key) begin
                        res = '{STAT_MATCH, slot_rids[pos], rid};
                        break;
                    end
                    pos = (pos + 1) & mask;
                end
            end
            OP_CLEAR: begin
                foreach (slot_used[i]) slot_used[i] = 1'b0;
                res.status = STAT_CLEARED;
            end
            default: ;  // no-op leaves the table alone
        endcase
        return res;
    endfunction

    task automatic flag_error(string msg);
        join_mismatches++;
        if (join_mismatches <= MAX_REPORTS) $display("%t  %s", $realtime, msg);
    endtask

    // one input transfer; the expectation is queued at the accepting edge
    task automatic send_item(op_t op, logic [KEY_W-1:0] key, logic [RID_W-1:0] rid,
                             logic typed = 1'b0, join_result_t typed_res = NO_RES);
        join_result_t pred;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rid, key};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        pred = hash_join_step(op, key, rid);
        if (typed) pred = typed_res;
        join_results_due = {join_results_due, pred};
        if (op != OP_NOP) items_sent++;
    endtask

    // drop valid and wait until every expected result has come back
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (join_results_due.size() != 0) @(posedge aclk);
    endtask

    // APB write, then a back-to-back read of the same register
    task automatic cfg_write(reg_idx_t idx, logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] field_mask;
        field_mask = (idx == REG_RADIX_BITS) ? PDATA_W'(5'h1F) : PDATA_W'(4'hF);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx) << 2;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == REG_RADIX_BITS) cur_radix = value[RADIX_W-1:0];
        else                       cur_tbits = value[TBITS_W-1:0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if ((prdata & field_mask) !== (value & field_mask))
            flag_error($sformatf("register %0d read back %h, wrote %h",
                                 idx, prdata & field_mask, value & field_mask));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // one random bucket: new geometry, usually a clear, builds, then probes
    task automatic run_join_bucket();
        logic [KEY_W-1:0]   built_keys [$];
        logic [KEY_W-1:0]   key;
        logic [PDATA_W-1:0] upper;
        logic [TBITS_W-1:0] tbits;
        logic [RADIX_W-1:0] radix;
        int unsigned        size;
        int unsigned        n_build;
        int unsigned        pick;
        wait_for_drain();
        pick = $urandom_range(99);
        if (pick < 10)      tbits = TBITS_W'($urandom_range(1));
        else if (pick < 80) tbits = TBITS_W'($urandom_range(6, 2));
        else if (pick < 95) tbits = TBITS_W'($urandom_range(10, 7));
        else                tbits = TBITS_W'($urandom_range(15, 11));
        radix = RADIX_W'($urandom_range(31));
        upper = $urandom;
        cfg_write(REG_TABLE_BITS, {upper[PDATA_W-1:TBITS_W], tbits});
        upper = $urandom;
        cfg_write(REG_RADIX_BITS, {upper[PDATA_W-1:RADIX_W], radix});
        // skipping the clear now and then leaves stale entries in play
        if ($urandom_range(4) != 0) send_item(OP_CLEAR, $urandom, $urandom);
        size    = slots_in_use(tbits);
        n_build = size / 4;
        if (n_build > 24) n_build = $urandom_range(24, 8);
        if (n_build == 0) n_build = 1;
        if (size <= 16 && $urandom_range(3) == 0) n_build = size + $urandom_range(2, 1);
        repeat (n_build) begin
            pick = $urandom_range(99);
            if (built_keys.size() != 0 && pick < 15)
                key = built_keys[$urandom_range(built_keys.size() - 1)];
            else if (built_keys.size() != 0 && pick < 35)
                // same home slot, different key
                key = built_keys[$urandom_range(built_keys.size() - 1)] + (size << radix);
            else
                key = $urandom;
            send_item(OP_BUILD, key, $urandom);
            built_keys = {built_keys, key};
        end
        repeat (2 * n_build + 4) begin
            pick = $urandom_range(99);
            key  = built_keys[$urandom_range(built_keys.size() - 1)];
            if (pick < 5)
                send_item(op_t'($urandom_range(3)), $urandom, $urandom);
            else if (pick < 60)
                send_item(OP_PROBE, key, $urandom);
            else if (pick < 75)
                send_item(OP_PROBE, key ^ (32'h1 << $urandom_range(31)), $urandom);
            else
                send_item(OP_PROBE, $urandom, $urandom);
        end
    endtask

    // result side: random back-pressure and in-order checking
    always @(posedge aclk) begin : result_monitor
        join_result_t got;
        join_result_t want;
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (aresetn && m_tvalid && m_tready) begin
            got = '{status_t'(m_tuser), m_tdata[RID_W-1:0], m_tdata[M_TDATA_W-1:RID_W]};
            if (join_results_due.size() == 0) begin
                flag_error($sformatf("result with nothing expected: status=%0d r=%h s=%h",
                                     got.status, got.r_rid, got.s_rid));
            end else begin
                want = join_results_due.pop_front();
                if (got.status !== want.status || got.r_rid !== want.r_rid ||
                    got.s_rid !== want.s_rid)
                    flag_error($sformatf(
                        "result mismatch: expected status=%0d r=%h s=%h, got status=%0d r=%h s=%h",
                        want.status, want.r_rid, want.s_rid,
                        got.status, got.r_rid, got.s_rid));
            end
        end
    end

    initial begin : stimulus
        int unsigned phase_start;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed rows; register rows wait for the table to go quiet
        for (int i = 0; i < N_ROWS; i++) begin
            case (DIRECTED_ROWS[i].kind)
                ROW_ITEM: send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].key,
                                    DIRECTED_ROWS[i].rid, DIRECTED_ROWS[i].typed,
                                    DIRECTED_ROWS[i].res);
                ROW_SET_RADIX: begin
                    wait_for_drain();
                    cfg_write(REG_RADIX_BITS, DIRECTED_ROWS[i].key);
                end
                default: begin
                    wait_for_drain();
                    cfg_write(REG_TABLE_BITS, DIRECTED_ROWS[i].key);
                end
            endcase
        end

        // random buckets under three throttle mixes
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 54 : 0;
            recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 16 : 0;
            phase_start   = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) run_join_bucket();
        end

        wait_for_drain();
        // long enough for a full clear or a whole-table walk to show up
        repeat (DEPTH + 16) @(posedge aclk);
        if (join_mismatches == 0 && join_results_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

endmodule
